### rtl/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package utf8sd_pkg;

   localparam int unsigned CP_W     = 31;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned REM_W    = 3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_WIDE  = 2'd2;

   localparam logic WIDE_CHARS_RESET = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_WIDE    = 2'd2,
      MODE_DROP    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } item_type;

   typedef struct packed {
      logic                valid;
      logic [CP_W-1:0]     code_point;
      logic [STATUS_W-1:0] status;
      logic                last_result;
   } result_type;

endpackage

### rtl/utf8sd_in_stage.sv
// Input register stage: holds one octet until the decode stage can take it.
module utf8sd_in_stage
   import utf8sd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   item_type item_ff;
   logic     in_ready;

   assign in_ready   = !valid_ff || advance;
   assign req_stall  = !in_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

### rtl/utf8sd_decode.sv
// Decode state and the per-octet lead/continuation logic, plus the width register.
module utf8sd_decode
   import utf8sd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_wide_chars_32bit,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   logic              wide_ff;
   mode_type          mode_ff, mode_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [CP_W-1:0]   acc_ff, acc_in;

   logic [7:0]        b;
   logic              eos;
   logic              lead_bad;
   logic [REM_W-1:0]  lead_len;
   logic [CP_W-1:0]   lead_bits;
   logic [REM_W-1:0]  rem_dec;
   logic [CP_W-1:0]   acc_shift;
   logic              fail;
   result_type        res;

   assign csr_ready = 1'b1;
   assign b         = item.data_byte;
   assign eos       = item.end_of_string;
   assign rem_dec   = rem_ff - REM_W'(1);
   assign acc_shift = {acc_ff[CP_W-7:0], b[5:0]};

   // priority match of the lead octet
   always_comb begin
      lead_bad  = 1'b0;
      lead_len  = '0;
      lead_bits = '0;
      if (b[7] == 1'b0) begin
         lead_bits = CP_W'(b);
      end else if (b[7:5] == 3'b110) begin
         lead_len  = REM_W'(1);
         lead_bits = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
         lead_len  = REM_W'(2);
         lead_bits = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
         lead_len  = REM_W'(3);
         lead_bits = CP_W'(b[2:0]);
      end else if (b[7:2] == 6'b111110) begin
         lead_len  = REM_W'(4);
         lead_bits = CP_W'(b[1:0]);
      end else if (b[7:1] == 7'b1111110) begin
         lead_len  = REM_W'(5);
         lead_bits = CP_W'(b[0]);
      end else begin
         lead_bad = 1'b1;
      end
   end

   always_comb begin
      mode_in         = mode_ff;
      rem_in          = rem_ff;
      acc_in          = acc_ff;
      fail            = 1'b0;
      res.valid       = 1'b0;
      res.code_point  = '0;
      res.status      = ST_OK;
      res.last_result = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (lead_bad) begin
               fail = 1'b1;
            end else if (lead_len == '0) begin
               res.valid       = 1'b1;
               res.code_point  = lead_bits;
               res.last_result = eos;
            end else if (eos) begin
               fail = 1'b1;
            end else begin
               rem_in = lead_len;
               if (lead_len > REM_W'(2) && !wide_ff) begin
                  mode_in = MODE_WIDE;
                  acc_in  = '0;
               end else begin
                  mode_in = MODE_COLLECT;
                  acc_in  = lead_bits;
               end
            end
         end
         MODE_COLLECT: begin
            if (b[7:6] != 2'b10) begin
               fail = 1'b1;
            end else begin
               rem_in = rem_dec;
               if (rem_dec == '0) begin
                  mode_in         = MODE_IDLE;
                  acc_in          = '0;
                  res.valid       = 1'b1;
                  res.code_point  = acc_shift;
                  res.last_result = eos;
               end else begin
                  acc_in = acc_shift;
                  if (eos) begin
                     fail = 1'b1;
                  end
               end
            end
         end
         MODE_WIDE: begin
            // continuation octets are only counted here, not checked
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               mode_in         = eos ? MODE_IDLE : MODE_DROP;
               acc_in          = '0;
               res.valid       = 1'b1;
               res.status      = ST_TOO_WIDE;
               res.last_result = 1'b1;
            end else if (eos) begin
               fail = 1'b1;
            end
         end
         MODE_DROP: begin
            if (eos) begin
               mode_in = MODE_IDLE;
               rem_in  = '0;
               acc_in  = '0;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
         end
      endcase

      if (fail) begin
         mode_in         = eos ? MODE_IDLE : MODE_DROP;
         rem_in          = '0;
         acc_in          = '0;
         res.valid       = 1'b1;
         res.code_point  = '0;
         res.status      = ST_MALFORMED;
         res.last_result = 1'b1;
      end
   end

   always_comb begin
      result       = res;
      result.valid = res.valid && fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= WIDE_CHARS_RESET;
         mode_ff <= MODE_IDLE;
         rem_ff  <= '0;
         acc_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            wide_ff <= csr_wide_chars_32bit;
         end
         if (fire) begin
            mode_ff <= mode_in;
            rem_ff  <= rem_in;
            acc_ff  <= acc_in;
         end
      end
   end

endmodule

### rtl/utf8sd_out_stage.sv
// Result register: holds a decoded transaction until the consumer takes it.
module utf8sd_out_stage
   import utf8sd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  result_type          result,
   output logic                out_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CP_W-1:0]     rsp_code_point,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last_result
);

   logic       valid_ff;
   result_type data_ff;

   assign out_ready       = !valid_ff || !rsp_stall;
   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = data_ff.code_point;
   assign rsp_status      = data_ff.status;
   assign rsp_last_result = data_ff.last_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_ready) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && result.valid) begin
         data_ff <= result;
      end
   end

endmodule

### rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder: one octet per cycle in unless stalled, one code point or error status out.
// An accepted octet goes through the input register, and its result through the result register, to rsp_valid.
// Throughput: one octet per cycle; the input and result registers both move
// whenever the result register is empty or being taken.
// Reset (synchronous, active high): decoder idle awaiting a lead byte, no
// result pending, wide_chars_32bit set to 1.
module utf8_stream_decoder
   import utf8sd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_string,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CP_W-1:0]     rsp_code_point,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last_result,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_wide_chars_32bit
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       out_ready;
   logic       fire;
   result_type result;

   assign req_item.data_byte     = req_data_byte;
   assign req_item.end_of_string = req_end_of_string;
   assign fire                   = item_valid && out_ready;

   utf8sd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   utf8sd_decode u_decode (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_wide_chars_32bit (csr_wide_chars_32bit),
      .fire                 (fire),
      .item                 (item),
      .result               (result)
   );

   utf8sd_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .result          (result),
      .out_ready       (out_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_status      (rsp_status),
      .rsp_last_result (rsp_last_result)
   );

endmodule

### tb/sv/utf8_stream_decoder_checker.sv
// Checker for the UTF-8 stream decoder: predicts each decoded character and compares results.
module utf8_stream_decoder_checker
   import utf8sd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_string,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [CP_W-1:0]     rsp_code_point,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic                rsp_last_result,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic                csr_wide_chars_32bit,
   output int                  mismatch_count,
   output int                  outstanding
);

   typedef struct packed {
      logic [CP_W-1:0]     code_point;
      logic [STATUS_W-1:0] status;
      logic                last_result;
   } decoded_char_type;

   decoded_char_type expected_chars[$];
   mode_type         dec_mode     = MODE_IDLE;
   logic [REM_W-1:0] octets_left  = '0;
   logic [CP_W-1:0]  partial_cp   = '0;
   logic             wide_allowed = WIDE_CHARS_RESET;
   int               fail_total   = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic void push_char(input logic [CP_W-1:0] cp, input logic [STATUS_W-1:0] st,
                                     input logic last);
      expected_chars.push_back('{cp, st, last});
   endfunction

   // An error closes the string; anything left before the end marker is dropped
   function automatic void flag_malformed(input logic eos);
      dec_mode    = eos ? MODE_IDLE : MODE_DROP;
      octets_left = '0;
      partial_cp  = '0;
      push_char('0, ST_MALFORMED, 1'b1);
   endfunction

   function automatic void decode_octet(input logic [7:0] octet, input logic eos);
      int follow;
      case (dec_mode)
         MODE_IDLE: begin
            casez (octet)
               8'b0???????: follow = 0;
               8'b110?????: follow = 1;
               8'b1110????: follow = 2;
               8'b11110???: follow = 3;
               8'b111110??: follow = 4;
               8'b1111110?: follow = 5;
               default:     follow = 6;
            endcase
            if (follow == 6) begin
               flag_malformed(eos);
            end else if (follow == 0) begin
               push_char(CP_W'(octet), ST_OK, eos);
            end else if (eos) begin
               flag_malformed(eos);
            end else begin
               octets_left = REM_W'(follow);
               // the width setting is taken at the lead byte only
               if (follow > 2 && !wide_allowed) begin
                  dec_mode   = MODE_WIDE;
                  partial_cp = '0;
               end else begin
                  dec_mode   = MODE_COLLECT;
                  partial_cp = CP_W'(octet & (8'hFF >> (follow + 2)));
               end
            end
         end
         MODE_COLLECT: begin
            if (octet[7:6] != 2'b10) begin
               flag_malformed(eos);
            end else begin
               partial_cp  = {partial_cp[CP_W-7:0], octet[5:0]};
               octets_left = octets_left - 1'b1;
               if (octets_left == '0) begin
                  push_char(partial_cp, ST_OK, eos);
                  dec_mode   = MODE_IDLE;
                  partial_cp = '0;
               end else if (eos) begin
                  flag_malformed(eos);
               end
            end
         end
         MODE_WIDE: begin
            octets_left = octets_left - 1'b1;
            if (octets_left == '0) begin
               dec_mode   = eos ? MODE_IDLE : MODE_DROP;
               partial_cp = '0;
               push_char('0, ST_TOO_WIDE, 1'b1);
            end else if (eos) begin
               flag_malformed(eos);
            end
         end
         default: begin
            if (eos) begin
               dec_mode    = MODE_IDLE;
               octets_left = '0;
               partial_cp  = '0;
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      decoded_char_type head;
      if (reset) begin
         expected_chars.delete();
         dec_mode     = MODE_IDLE;
         octets_left  = '0;
         partial_cp   = '0;
         wide_allowed = WIDE_CHARS_RESET;
      end else begin
         if (csr_valid && csr_ready)
            wide_allowed = csr_wide_chars_32bit;
         if (req_valid && !req_stall)
            decode_octet(req_data_byte, req_end_of_string);
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected transaction: code_point %h status %0d last_result %b",
                        $time, rsp_code_point, rsp_status, rsp_last_result);
               fail_total++;
            end else begin
               head = expected_chars.pop_front();
               if (rsp_code_point !== head.code_point) begin
                  $display("%0t: code_point expected %h actual %h",
                           $time, head.code_point, rsp_code_point);
                  fail_total++;
               end
               if (rsp_status !== head.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, head.status, rsp_status);
                  fail_total++;
               end
               if (rsp_last_result !== head.last_result) begin
                  $display("%0t: last_result expected %b actual %b",
                           $time, head.last_result, rsp_last_result);
                  fail_total++;
               end
            end
         end
      end
      mismatch_count <= fail_total;
      outstanding    <= expected_chars.size();
   end

endmodule

### tb/sv/tb_utf8_stream_decoder.sv
// Testbench top for the UTF-8 stream decoder: clock, reset, stimulus and verdict.
module tb_utf8_stream_decoder
   import utf8sd_pkg::*;
;

   logic                clock;
   logic                reset                = 1'b1;
   logic                req_valid            = 1'b0;
   logic [7:0]          req_data_byte        = 8'h00;
   logic                req_end_of_string    = 1'b0;
   logic                rsp_stall            = 1'b0;
   logic                csr_valid            = 1'b0;
   logic                csr_wide_chars_32bit = 1'b1;
   logic                req_stall;
   logic                rsp_valid;
   logic [CP_W-1:0]     rsp_code_point;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last_result;
   logic                csr_ready;
   int                  mismatch_count;
   int                  outstanding;

   bit                  calm        = 1'b0;
   int                  octets_sent = 0;
   logic [7:0]          octet_q[$];

   utf8_stream_decoder i_dut (.*);

   utf8_stream_decoder_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(0, 99) < 28);

   task automatic send_octet(input logic [7:0] octet, input logic eos);
      while (!calm && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= octet;
      req_end_of_string <= eos;
      do @(posedge clock); while (req_stall);
      octets_sent++;
   endtask

   task automatic send_queued();
      for (int k = 0; k < octet_q.size(); k++)
         send_octet(octet_q[k], k == octet_q.size() - 1);
   endtask

   // Drain: the checker's count is registered, and the decoder may still hold an octet
   task automatic wait_idle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_wide(input logic wide);
      wait_idle();
      csr_valid            <= 1'b1;
      csr_wide_chars_32bit <= wide;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed strings with random payload; a share is corrupted or cut short
   task automatic send_random_string();
      int n_chars, len, pick, fault, cut;
      octet_q.delete();
      n_chars = $urandom_range(1, 5);
      repeat (n_chars) begin
         pick = $urandom_range(0, 9);
         len  = (pick < 4) ? 1 : (pick < 6) ? 2 : (pick < 8) ? 3 :
                (pick == 8) ? 4 : $urandom_range(5, 6);
         if (len == 1)
            octet_q.push_back({1'b0, 7'($urandom)});
         else
            octet_q.push_back(~(8'hFF >> len) | (8'($urandom) & (8'hFF >> (len + 1))));
         repeat (len - 1) octet_q.push_back({2'b10, 6'($urandom)});
      end
      fault = $urandom_range(0, 99);
      if (fault < 6) begin
         octet_q[$urandom_range(0, octet_q.size() - 1)] = 8'($urandom);
      end else if (fault < 11) begin
         cut = $urandom_range(1, octet_q.size());
         while (octet_q.size() > cut) void'(octet_q.pop_back());
      end else if (fault < 14) begin
         octet_q.delete();
         repeat ($urandom_range(1, 6)) octet_q.push_back(8'($urandom));
      end
      send_queued();
   endtask

   task automatic run_phase(input logic wide, input int quota);
      write_wide(wide);
      octets_sent = 0;
      while (octets_sent < quota) send_random_string();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // wide mode from reset: NUL, 2- and 3-byte maxima, full 31-bit code point
      octet_q = '{8'h00, 8'hDF, 8'hBF, 8'hEF, 8'hBF, 8'hBF};
      send_queued();
      octet_q = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
      send_queued();
      // bad lead then dropped tail, stray continuation as lead, bad continuation
      octet_q = '{8'hFE, 8'h41};
      send_queued();
      send_octet(8'h80, 1'b1);
      octet_q = '{8'hC2, 8'h41};
      send_queued();
      // lead byte carrying the end marker is truncation
      send_octet(8'hC2, 1'b1);
      // narrowing mid-sequence must not affect the 4-byte form already started
      send_octet(8'hF0, 1'b0);
      write_wide(1'b0);
      octet_q = '{8'h9F, 8'hBF, 8'hBF};
      send_queued();
      // too wide, then the rest of the string dropped
      octet_q = '{8'hF4, 8'h80, 8'h80, 8'h80, 8'h41};
      send_queued();
      // truncation wins over too wide
      octet_q = '{8'hF8, 8'h80};
      send_queued();

      run_phase(1'b1, 300);
      calm = 1'b1;
      run_phase(1'b0, 250);
      calm = 1'b0;
      run_phase(1'b1, 250);
      run_phase(1'b0, 250);

      wait_idle();
      if (mismatch_count == 0)
         $display("utf8_stream_decoder test passed");
      else
         $display("utf8_stream_decoder test failed");
      $finish;
   end

   initial begin
      #(12 * 300000);
      $display("utf8_stream_decoder test failed");
      $finish;
   end

endmodule

### utf8_stream_decoder.f
rtl/utf8sd_pkg.sv
rtl/utf8sd_in_stage.sv
rtl/utf8sd_decode.sv
rtl/utf8sd_out_stage.sv
rtl/utf8_stream_decoder.sv
tb/sv/utf8_stream_decoder_checker.sv
tb/sv/tb_utf8_stream_decoder.sv
